[hdl/dmp_pkg.sv]
// dmp_pkg: shared constants, codes and types of the depth min-pool downscaler.
// No dependencies; compiled before every other file of the block.
package dmp_pkg;

  // Default sizes of the column store and the block counters
  localparam int unsigned MAX_LINE_DEF  = 1024;
  localparam int unsigned MAX_BLOCK_DEF = 64;

  // Field widths fixed by the port definition
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned MIN_W     = 13;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned BLK_REG_W = 7;
  localparam int unsigned CFG_IDX_W = 3;

  // Depth reported for a block without a valid reading
  localparam logic [MIN_W-1:0] NO_READING = MIN_W'(6000);

  // Register reset values
  localparam logic [CFG_W-1:0]     LINE_WIDTH_RST   = CFG_W'(320);
  localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = CFG_W'(240);
  localparam logic [BLK_REG_W-1:0] BLOCK_W_RST      = BLK_REG_W'(1);
  localparam logic [BLK_REG_W-1:0] BLOCK_H_RST      = BLK_REG_W'(1);
  localparam logic [CFG_W-1:0]     OUT_WIDTH_RST    = CFG_W'(320);
  localparam logic [CFG_W-1:0]     OUT_HEIGHT_RST   = CFG_W'(240);

  // Register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BLOCK_W      = 3'd2,
    CFG_BLOCK_H      = 3'd3,
    CFG_OUT_WIDTH    = 3'd4,
    CFG_OUT_HEIGHT   = 3'd5
  } cfg_idx_e;

  // Control sequencer: stripe set-up divide, then streaming
  typedef enum logic [1:0] {
    ST_START,
    ST_WAIT,
    ST_RUN
  } ctl_state_e;

  // Per-pixel control handed from the counters to the accumulator
  typedef struct packed {
    logic                 first;   // opens a new block: ignore the stored value
    logic                 emit;    // closes the block: send the result
    logic                 last;    // final block of the frame
    logic [OUT_IDX_W-1:0] row;     // output row of the block
    logic [MIN_W-1:0]     cand;    // clipped depth of this pixel
  } pix_ctl_t;

endpackage

[hdl/dmp_if.sv]
// dmp_if: valid/ready channel interfaces for depth pixels and pooled results.
// Depends on dmp_pkg for the field widths.
interface dmp_pix_if;
  logic                         valid;
  logic                         ready;
  logic [dmp_pkg::DEPTH_W-1:0]  depth;

  modport source (output valid, depth, input ready);
  modport sink   (input valid, depth, output ready);
endinterface

interface dmp_res_if;
  logic                           valid;
  logic                           ready;
  logic [dmp_pkg::OUT_IDX_W-1:0]  out_row;
  logic [dmp_pkg::OUT_IDX_W-1:0]  out_col;
  logic [dmp_pkg::MIN_W-1:0]      min_depth;
  logic                           frame_last;

  modport source (output valid, out_row, out_col, min_depth, frame_last, input ready);
  modport sink   (input valid, out_row, out_col, min_depth, frame_last, output ready);
endinterface

[hdl/dmp_div.sv]
// dmp_div: restoring divider, one quotient bit per cycle.
// Stand-alone; used by the top level to place a line's pixels in blocks.
module dmp_div #(
  parameter int unsigned NUM_W = 10,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One shift-subtract step: bring down the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
    done_d = (cnt_q == CNT_W'(1)) && !start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[hdl/dmp_acc.sv]
// dmp_acc: per-column minimum store with read-modify-write and result register.
// Depends on dmp_pkg (pix_ctl_t, widths) and dmp_res_if.
module dmp_acc #(
  parameter int unsigned MAX_LINE = dmp_pkg::MAX_LINE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [$clog2(MAX_LINE)-1:0] req_ocol_i,
  input  dmp_pkg::pix_ctl_t          req_ctl_i,
  output logic                       req_ready_o,
  dmp_res_if.source                  res_o
);

  localparam int unsigned COL_W = $clog2(MAX_LINE);

  // Column store: one running minimum per output column
  logic [dmp_pkg::MIN_W-1:0] mem_q [MAX_LINE];
  logic [dmp_pkg::MIN_W-1:0] rd_q;

  // Update stage
  logic                      s1_valid_q, s1_valid_d;
  logic [COL_W-1:0]          s1_ocol_q;
  dmp_pkg::pix_ctl_t         s1_ctl_q;

  // Last write, forwarded to a read that saw the old entry
  logic                      fwd_valid_q;
  logic [COL_W-1:0]          fwd_addr_q;
  logic [dmp_pkg::MIN_W-1:0] fwd_data_q;

  logic                      res_valid_q, res_valid_d;
  logic [dmp_pkg::OUT_IDX_W-1:0] res_row_q, res_col_q;
  logic [dmp_pkg::MIN_W-1:0] res_min_q;
  logic                      res_last_q;

  logic                      req_acc;
  logic                      out_free;
  logic                      s1_adv;
  logic [dmp_pkg::MIN_W-1:0] prev;
  logic [dmp_pkg::MIN_W-1:0] cur;

  // Merge the pixel with the stored minimum
  always_comb begin
    prev     = (fwd_valid_q && fwd_addr_q == s1_ocol_q) ? fwd_data_q : rd_q;
    cur      = s1_ctl_q.first ? s1_ctl_q.cand :
               ((prev < s1_ctl_q.cand) ? prev : s1_ctl_q.cand);
    out_free = !res_valid_q || res_o.ready;
    s1_adv   = s1_valid_q && (!s1_ctl_q.emit || out_free);
    req_ready_o = !s1_valid_q || s1_adv;
    req_acc  = req_valid_i && req_ready_o;

    s1_valid_d = s1_valid_q;
    if (req_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    res_valid_d = res_valid_q;
    if (s1_adv && s1_ctl_q.emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // Store read port: data registered, issued as the pixel enters
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rd_q <= mem_q[req_ocol_i];
    end
  end

  // Store write port: written as the pixel leaves the update stage
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_ocol_q] <= cur;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      if (s1_adv) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_ocol_q <= req_ocol_i;
      s1_ctl_q  <= req_ctl_i;
    end
    if (s1_adv) begin
      fwd_addr_q <= s1_ocol_q;
      fwd_data_q <= cur;
    end
    if (s1_adv && s1_ctl_q.emit) begin
      res_row_q  <= s1_ctl_q.row;
      res_col_q  <= dmp_pkg::OUT_IDX_W'(s1_ocol_q);
      res_min_q  <= cur;
      res_last_q <= s1_ctl_q.last;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.out_row    = res_row_q;
  assign res_o.out_col    = res_col_q;
  assign res_o.min_depth  = res_min_q;
  assign res_o.frame_last = res_last_q;

endmodule

[hdl/depth_min_pool_downscaler.sv]
// depth_min_pool_downscaler: top level; registers, raster counters, sequencer.
// Depends on dmp_pkg, dmp_if, dmp_div and dmp_acc.
//
//   channel  | dir | words                         | handshake
//   pix_i    | in  | depth                         | valid/ready
//   res_o    | out | out_row out_col min_depth     | valid/ready
//            |     | frame_last                    |
//   cfg      | in  | cfg_idx_i cfg_data_i          | cfg_we_i, no wait
//
// One depth word a cycle while ready is high; a result passes the update stage
// and then the result register. The column store is one read port and one
// write port, one read-modify-write per word, with the previous write forwarded
// when it hits the same column. After reset and after each register write ready
// stays low while the dividers place the line start in blocks.
// A closing word whose result finds the result register full and untaken waits
// in the update stage, and ready stays low until that result is taken.
module depth_min_pool_downscaler #(
  parameter int unsigned MAX_LINE  = dmp_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_BLOCK = dmp_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dmp_pix_if.sink                       pix_i,
  dmp_res_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmp_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_LINE);
  localparam int unsigned LW_W  = $clog2(MAX_LINE + 1);
  localparam int unsigned BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUB_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  // Registers
  logic [dmp_pkg::CFG_W-1:0]     line_width_q, frame_height_q, out_width_q, out_height_q;
  logic [dmp_pkg::BLK_REG_W-1:0] block_w_q, block_h_q;

  // Raster counters and stripe position
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [COL_W-1:0] in_row_q, in_row_d;
  logic [SUB_W-1:0] sub_row_q, sub_row_d;
  logic [COL_W-1:0] blk_row_q, blk_row_d;
  logic [COL_W-1:0] cur_ocol_q, cur_ocol_d;
  logic [SUB_W-1:0] cur_sub_q, cur_sub_d;
  logic [COL_W-1:0] start_ocol_q;
  logic [SUB_W-1:0] start_sub_q;

  dmp_pkg::ctl_state_e state_q, state_d;

  logic [LW_W-1:0]  lw, fh;
  logic [BLK_W-1:0] bw, bh;
  logic [SUB_W-1:0] sub_row_eff;
  logic             div_start;
  logic             div_done;
  logic             div_start_done;
  logic             div_cur_done;
  logic [COL_W-1:0] q_start, q_cur;
  logic [BLK_W-1:0] r_start, r_cur;
  logic             acc_ready;
  logic             accept;
  logic             in_line;
  logic             hit;
  logic             line_end;
  dmp_pkg::pix_ctl_t pix_ctl;

  // Effective register values: zero acts as one, large values saturate
  always_comb begin
    lw = (line_width_q == '0) ? LW_W'(1) :
         ((32'(line_width_q) > MAX_LINE) ? LW_W'(MAX_LINE) : LW_W'(line_width_q));
    fh = (frame_height_q == '0) ? LW_W'(1) :
         ((32'(frame_height_q) > MAX_LINE) ? LW_W'(MAX_LINE) : LW_W'(frame_height_q));
    bw = (block_w_q == '0) ? BLK_W'(1) :
         ((32'(block_w_q) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : BLK_W'(block_w_q));
    bh = (block_h_q == '0) ? BLK_W'(1) :
         ((32'(block_h_q) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : BLK_W'(block_h_q));
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= dmp_pkg::LINE_WIDTH_RST;
      frame_height_q <= dmp_pkg::FRAME_HEIGHT_RST;
      block_w_q      <= dmp_pkg::BLOCK_W_RST;
      block_h_q      <= dmp_pkg::BLOCK_H_RST;
      out_width_q    <= dmp_pkg::OUT_WIDTH_RST;
      out_height_q   <= dmp_pkg::OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (dmp_pkg::cfg_idx_e'(cfg_idx_i))
        dmp_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        dmp_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        dmp_pkg::CFG_BLOCK_W:      block_w_q      <= cfg_data_i[dmp_pkg::BLK_REG_W-1:0];
        dmp_pkg::CFG_BLOCK_H:      block_h_q      <= cfg_data_i[dmp_pkg::BLK_REG_W-1:0];
        dmp_pkg::CFG_OUT_WIDTH:    out_width_q    <= cfg_data_i;
        dmp_pkg::CFG_OUT_HEIGHT:   out_height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line start and current pixel placed in blocks by division
  dmp_div #(.NUM_W(COL_W), .DEN_W(BLK_W)) u_div_start (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (COL_W'(32'(lw) - 32'd1)),
    .den_i   (bw),
    .done_o  (div_start_done),
    .quot_o  (q_start),
    .rem_o   (r_start)
  );

  dmp_div #(.NUM_W(COL_W), .DEN_W(BLK_W)) u_div_cur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (COL_W'(32'(lw) - 32'd1 - 32'(in_col_q))),
    .den_i   (bw),
    .done_o  (div_cur_done),
    .quot_o  (q_cur),
    .rem_o   (r_cur)
  );

  // Both dividers start together and finish together
  assign div_done = div_start_done && div_cur_done;

  // Sequencer: set-up divide after reset or a register write, then stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmp_pkg::ST_START;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      dmp_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = dmp_pkg::ST_WAIT;
      end
      dmp_pkg::ST_WAIT: begin
        if (div_done) begin
          state_d = dmp_pkg::ST_RUN;
        end
      end
      dmp_pkg::ST_RUN: ;
      default: state_d = dmp_pkg::ST_START;
    endcase
    if (cfg_we_i) begin
      state_d = dmp_pkg::ST_START;
    end
  end

  assign pix_i.ready = (state_q == dmp_pkg::ST_RUN) && acc_ready;
  assign accept      = pix_i.valid && pix_i.ready;

  // Block membership of the incoming pixel
  always_comb begin
    sub_row_eff = (32'(sub_row_q) >= 32'(bh)) ? '0 : sub_row_q;
    in_line     = 32'(in_col_q) < 32'(lw);
    hit         = in_line && (32'(cur_ocol_q) < 32'(out_width_q)) &&
                  (32'(blk_row_q) < 32'(out_height_q));
    line_end    = (32'(in_col_q) + 32'd1) >= 32'(lw);

    pix_ctl.first = (sub_row_eff == '0) &&
                    ((32'(cur_sub_q) == 32'(bw) - 32'd1) || (in_col_q == '0));
    pix_ctl.emit  = (32'(sub_row_eff) == 32'(bh) - 32'd1) && (cur_sub_q == '0);
    pix_ctl.last  = ((32'(blk_row_q) + 32'd1) == 32'(out_height_q)) && (cur_ocol_q == '0);
    pix_ctl.row   = dmp_pkg::OUT_IDX_W'(blk_row_q);
    pix_ctl.cand  = (pix_i.depth != '0 && pix_i.depth < 16'(dmp_pkg::NO_READING)) ?
                    dmp_pkg::MIN_W'(pix_i.depth) : dmp_pkg::NO_READING;
  end

  // Counter advance: columns count down in mirrored blocks
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    sub_row_d  = sub_row_q;
    blk_row_d  = blk_row_q;
    cur_ocol_d = cur_ocol_q;
    cur_sub_d  = cur_sub_q;
    if (state_q == dmp_pkg::ST_WAIT && div_done) begin
      cur_ocol_d = q_cur;
      cur_sub_d  = SUB_W'(r_cur);
    end else if (accept) begin
      sub_row_d = sub_row_eff;
      if (line_end) begin
        in_col_d   = '0;
        cur_ocol_d = start_ocol_q;
        cur_sub_d  = start_sub_q;
        if ((32'(in_row_q) + 32'd1) >= 32'(fh)) begin
          in_row_d  = '0;
          sub_row_d = '0;
          blk_row_d = '0;
        end else begin
          in_row_d = in_row_q + COL_W'(1);
          if ((32'(sub_row_eff) + 32'd1) >= 32'(bh)) begin
            sub_row_d = '0;
            blk_row_d = blk_row_q + COL_W'(1);
          end else begin
            sub_row_d = sub_row_eff + SUB_W'(1);
          end
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
        if (cur_sub_q == '0) begin
          cur_sub_d  = SUB_W'(32'(bw) - 32'd1);
          cur_ocol_d = cur_ocol_q - COL_W'(1);
        end else begin
          cur_sub_d = cur_sub_q - SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      sub_row_q  <= '0;
      blk_row_q  <= '0;
      cur_ocol_q <= '0;
      cur_sub_q  <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      sub_row_q  <= sub_row_d;
      blk_row_q  <= blk_row_d;
      cur_ocol_q <= cur_ocol_d;
      cur_sub_q  <= cur_sub_d;
    end
  end

  // Line start position, held until the next set-up
  always_ff @(posedge clk_i) begin
    if (state_q == dmp_pkg::ST_WAIT && div_done) begin
      start_ocol_q <= q_start;
      start_sub_q  <= SUB_W'(r_start);
    end
  end

  dmp_acc #(.MAX_LINE(MAX_LINE)) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept && hit),
    .req_ocol_i  (cur_ocol_q),
    .req_ctl_i   (pix_ctl),
    .req_ready_o (acc_ready),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // Words are taken only once the line start is placed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |-> (state_q == dmp_pkg::ST_RUN))
    else $error("word accepted during set-up");

  // A register write closes the input for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !pix_i.ready)
    else $error("input open right after register write");

  // The frame's last block is the mirrored column zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_last) |-> (res_o.out_col == '0))
    else $error("frame end flagged away from column zero");
`endif

endmodule
